FILE: hdl/hfd_pkg.sv
// hfd_pkg: shared constants and queue entry type for the hash flow distributor
// no dependencies; imported by hfd_front, hfd_queue, hfd_back, hash_flow_distributor and the bench
`timescale 1ns / 1ps

package hfd_pkg;

    // key length counter width, covers keys of up to 8191 bytes
    localparam int LEN_W = 13;

    localparam logic [63:0] HASH_SEED = 64'h0000_000D_EADD_00DE;
    localparam logic [63:0] PR1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] PR2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] PR3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] PR4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] PR5 = 64'h27D4_EB2F_1656_67C5;

    localparam logic [63:0] LANE0_INIT = HASH_SEED + PR1 + PR2;
    localparam logic [63:0] LANE1_INIT = HASH_SEED + PR2;
    localparam logic [63:0] LANE2_INIT = HASH_SEED;
    localparam logic [63:0] LANE3_INIT = HASH_SEED - PR1;
    localparam logic [63:0] SHORT_INIT = HASH_SEED + PR5;

    // one classified beat handed from the front to the back
    typedef struct packed {
        logic             start;  // first word of a keyed record, reload lanes
        logic             keyed;
        logic             push;   // word carries key bytes to store
        logic             done;   // record ends with this beat
        logic [1:0]       widx;   // stripe word slot
        logic [LEN_W-1:0] len;    // key length after this beat
        logic [63:0]      word;   // key bytes, unused bytes zeroed
    } t_qent;

endpackage

FILE: hdl/hash_flow_distributor.sv
// a key word that does not close a 32-byte stripe passes the queue and is stored by the back;
// one that closes a stripe holds the back for a lane round on each of the 4 lanes
// a round-robin or hashed record result follows its last beat, hashed ones through the single two-stage
// multiplier, all through the modulo unit; the back takes one record at a time
// reset (synchronous, active low) clears counters, queue and output; num_outputs returns to 1
`timescale 1ns / 1ps

// hash_flow_distributor: top level, front classifier, beat queue and hashing back end
// depends on hfd_pkg, hfd_front, hfd_queue, hfd_back (and hfd_mul64 below it)
module hash_flow_distributor #(
    parameter int MAX_PORTS     = 16,
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: num_outputs
    input  logic         i_cfg_wen,
    input  logic [4:0]   i_cfg_wdata,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // key_word[63:0], key_bytes[67:64], zero pad
    input  logic         s_axis_tlast,   // last word of the record
    input  logic         s_axis_tuser,   // keyed
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // port_index[3:0], hash_value[67:4], port_count[131:68]
    output logic         m_axis_tuser    // by_hash
);
    import hfd_pkg::*;

    t_qent      w_f_ent;
    t_qent      w_q_ent;
    logic       w_q_wr;
    logic       w_q_full;
    logic       w_q_valid;
    logic       w_q_rd;
    logic [3:0] w_port;
    logic [63:0] w_hash;
    logic [63:0] w_count;

    // front: accept, clip to the key limit, mask unused bytes, mark record ends
    hfd_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_keyed     (s_axis_tuser),
        .i_key_word  (s_axis_tdata[63:0]),
        .i_key_bytes (s_axis_tdata[67:64]),
        .i_last      (s_axis_tlast),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr),
        .o_q_data    (w_f_ent)
    );

    // short queue so the front keeps taking beats while the back hashes, until it fills
    hfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_f_ent),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_ent)
    );

    // back: lane rounds, finalization, modulo, counters, output register
    hfd_back #(
        .MAX_PORTS (MAX_PORTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_valid    (w_q_valid),
        .o_q_rd       (w_q_rd),
        .i_q_data     (w_q_ent),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_port_index (w_port),
        .o_by_hash    (m_axis_tuser),
        .o_hash       (w_hash),
        .o_count      (w_count)
    );

    assign m_axis_tdata = {4'd0, w_count, w_hash, w_port};

endmodule

FILE: hdl/hfd_mul64.sv
// hfd_mul64: two-stage 64x64 multiplier keeping the low 64 product bits
// built from three 32x32 partial products; no dependencies
`timescale 1ns / 1ps

module hfd_mul64 (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] w_lh;
    logic [63:0] w_hl;

    assign w_lh = i_a[31:0] * i_b[63:32];
    assign w_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[31:0] * i_b[31:0];
        r_lh <= w_lh[31:0];
        r_hl <= w_hl[31:0];
        r_p  <= r_ll + {r_lh + r_hl, 32'd0};
    end

    assign o_p = r_p;

endmodule

FILE: hdl/hfd_front.sv
// hfd_front: accepts input beats, tracks key length and classifies each beat
// depends on hfd_pkg
`timescale 1ns / 1ps

module hfd_front #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_keyed,
    input  logic [63:0]   i_key_word,
    input  logic [3:0]    i_key_bytes,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output hfd_pkg::t_qent o_q_data
);
    import hfd_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] w_room;
    logic [LEN_W-1:0] w_after;
    logic [3:0]       w_nb;
    logic [3:0]       w_np;
    logic [63:0]      w_mask;

    always_comb begin
        w_nb    = (!i_last || i_key_bytes > 4'd8) ? 4'd8 : i_key_bytes;
        w_room  = LEN_W'(MAX_KEY_BYTES) - r_len;
        w_np    = (w_room < LEN_W'(w_nb)) ? w_room[3:0] : w_nb;
        w_after = r_len + LEN_W'(w_np);
        for (int k = 0; k < 8; k++) begin
            w_mask[k*8 +: 8] = (4'(k) < w_np) ? 8'hFF : 8'h00;
        end
    end

    assign o_ready = !i_q_full;
    assign o_q_wr  = i_valid && o_ready;

    always_comb begin
        o_q_data.start = i_keyed && (r_len == '0);
        o_q_data.keyed = i_keyed;
        o_q_data.push  = i_keyed && (w_np != 4'd0);
        o_q_data.done  = !i_keyed || i_last;
        o_q_data.widx  = r_len[4:3];
        o_q_data.len   = i_keyed ? w_after : '0;
        o_q_data.word  = i_key_word & w_mask;
    end

    always_comb begin
        n_len = r_len;
        if (o_q_wr) begin
            n_len = o_q_data.done ? '0 : w_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

endmodule

FILE: hdl/hfd_queue.sv
// hfd_queue: two-entry queue of classified beats between front and back
// depends on hfd_pkg
`timescale 1ns / 1ps

module hfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  hfd_pkg::t_qent i_wdata,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_rd,
    output hfd_pkg::t_qent o_rdata
);
    import hfd_pkg::*;

    t_qent      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= !r_wp;
            end
            if (i_rd) begin
                r_rp <= !r_rp;
            end
        end
    end

endmodule

FILE: hdl/hfd_back.sv
// hfd_back: hashing sequencer, modulo unit, record counters and output register
// depends on hfd_pkg and hfd_mul64
`timescale 1ns / 1ps

module hfd_back #(
    parameter int MAX_PORTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wen,
    input  logic [4:0]     i_cfg_wdata,
    input  logic           i_q_valid,
    output logic           o_q_rd,
    input  hfd_pkg::t_qent i_q_data,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic [3:0]     o_port_index,
    output logic           o_by_hash,
    output logic [63:0]    o_hash,
    output logic [63:0]    o_count
);
    import hfd_pkg::*;

    localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MW1  = 5'd1;
    localparam logic [4:0] S_MW2  = 5'd2;
    localparam logic [4:0] S_LR0  = 5'd3;
    localparam logic [4:0] S_LR1  = 5'd4;
    localparam logic [4:0] S_LR2  = 5'd5;
    localparam logic [4:0] S_F0   = 5'd6;
    localparam logic [4:0] S_FS1  = 5'd7;
    localparam logic [4:0] S_FS2  = 5'd8;
    localparam logic [4:0] S_M0   = 5'd9;
    localparam logic [4:0] S_M1   = 5'd10;
    localparam logic [4:0] S_M2   = 5'd11;
    localparam logic [4:0] S_M3   = 5'd12;
    localparam logic [4:0] S_FLEN = 5'd13;
    localparam logic [4:0] S_W0   = 5'd14;
    localparam logic [4:0] S_W1   = 5'd15;
    localparam logic [4:0] S_W2   = 5'd16;
    localparam logic [4:0] S_W3   = 5'd17;
    localparam logic [4:0] S_H1   = 5'd18;
    localparam logic [4:0] S_H2   = 5'd19;
    localparam logic [4:0] S_B0   = 5'd20;
    localparam logic [4:0] S_B1   = 5'd21;
    localparam logic [4:0] S_B2   = 5'd22;
    localparam logic [4:0] S_A0   = 5'd23;
    localparam logic [4:0] S_A1   = 5'd24;
    localparam logic [4:0] S_A2   = 5'd25;
    localparam logic [4:0] S_MOD  = 5'd26;
    localparam logic [4:0] S_RD   = 5'd27;
    localparam logic [4:0] S_OUT  = 5'd28;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // control state
    logic [4:0]  r_state, n_state;
    logic [4:0]  r_ret, n_ret;
    logic [4:0]  r_nout, n_nout;
    logic [63:0] r_total, n_total;
    logic        r_ov, n_ov;
    logic [MAX_PORTS-1:0] r_pv;

    // datapath
    logic [63:0] r_lane [4];
    logic [63:0] n_lane [4];
    logic [63:0] r_stripe [4];
    logic [63:0] n_stripe [4];
    logic [63:0] r_h, n_h;
    logic [63:0] r_mv, n_mv;
    logic [63:0] r_ma, n_ma;
    logic [63:0] r_mb, n_mb;
    logic [1:0]  r_li, n_li;
    logic [4:0]  r_i, n_i;
    logic [LEN_W-1:0] r_len, n_len;
    logic        r_done, n_done;
    logic [4:0]  r_rm, n_rm;
    logic [2:0]  r_mc, n_mc;
    logic        r_byh, n_byh;
    logic [3:0]  r_opi, n_opi;
    logic        r_obh, n_obh;
    logic [63:0] r_oh, n_oh;
    logic [63:0] r_ocnt, n_ocnt;

    // per-port counter memory with registered read
    logic [63:0] r_cnt_mem [MAX_PORTS];
    logic [63:0] r_rd_cnt;
    logic        r_rd_v;

    logic [63:0] w_p;
    logic [1:0]  w_sidx;
    logic [63:0] w_sword;
    logic [4:0]  w_left;
    logic [4:0]  w_n;
    logic [4:0]  w_rm;
    logic [5:0]  w_t;
    logic [PW-1:0] w_cidx;
    logic [63:0] w_newcnt;
    logic        w_cnt_wr;

    hfd_mul64 u_mul (
        .i_clk (i_clk),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_p   (w_p)
    );

    assign w_n = (r_nout == 5'd0) ? 5'd1 :
                 ((32'(r_nout) > MAX_PORTS) ? 5'(MAX_PORTS) : r_nout);
    assign w_sidx   = (r_state == S_LR0) ? r_li : r_i[4:3];
    assign w_sword  = r_stripe[w_sidx];
    assign w_left   = r_len[4:0] - r_i;
    assign w_cidx   = PW'(r_rm);
    assign w_newcnt = (r_rd_v ? r_rd_cnt : 64'd0) + 64'd1;

    // eight restoring remainder steps per cycle
    always_comb begin
        w_rm = r_rm;
        w_t  = '0;
        for (int k = 0; k < 8; k++) begin
            w_t = {w_rm, r_mv[63-k]};
            if (w_t >= {1'b0, w_n}) begin
                w_t = w_t - {1'b0, w_n};
            end
            w_rm = w_t[4:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_nout   = r_nout;
        n_total  = r_total;
        n_ov     = r_ov;
        n_lane   = r_lane;
        n_stripe = r_stripe;
        n_h      = r_h;
        n_mv     = r_mv;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_li     = r_li;
        n_i      = r_i;
        n_len    = r_len;
        n_done   = r_done;
        n_rm     = r_rm;
        n_mc     = r_mc;
        n_byh    = r_byh;
        n_opi    = r_opi;
        n_obh    = r_obh;
        n_oh     = r_oh;
        n_ocnt   = r_ocnt;
        o_q_rd   = 1'b0;
        w_cnt_wr = 1'b0;

        if (i_cfg_wen) begin
            n_nout = i_cfg_wdata;
        end
        if (r_ov && i_m_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_rd = 1'b1;
                    if (i_q_data.start) begin
                        n_lane[0] = LANE0_INIT;
                        n_lane[1] = LANE1_INIT;
                        n_lane[2] = LANE2_INIT;
                        n_lane[3] = LANE3_INIT;
                    end
                    if (i_q_data.push) begin
                        n_stripe[i_q_data.widx] = i_q_data.word;
                    end
                    n_len  = i_q_data.len;
                    n_done = i_q_data.done;
                    n_li   = 2'd0;
                    if (i_q_data.push && i_q_data.len[4:0] == 5'd0) begin
                        n_state = S_LR0;
                    end else if (i_q_data.done) begin
                        if (i_q_data.keyed && i_q_data.len != '0) begin
                            n_state = S_F0;
                        end else begin
                            n_h     = '0;
                            n_mv    = r_total;
                            n_byh   = 1'b0;
                            n_rm    = '0;
                            n_mc    = '0;
                            n_state = S_MOD;
                        end
                    end
                end
            end
            S_MW1: n_state = S_MW2;
            S_MW2: n_state = r_ret;
            // stripe lane rounds
            S_LR0: begin
                n_ma = w_sword; n_mb = PR2; n_ret = S_LR1; n_state = S_MW1;
            end
            S_LR1: begin
                n_ma = rotl(r_lane[r_li] + w_p, 31); n_mb = PR1;
                n_ret = S_LR2; n_state = S_MW1;
            end
            S_LR2: begin
                n_lane[r_li] = w_p;
                if (r_li == 2'd3) begin
                    n_state = r_done ? S_F0 : S_IDLE;
                end else begin
                    n_li = r_li + 2'd1; n_state = S_LR0;
                end
            end
            // finalization
            S_F0: begin
                if (r_len >= LEN_W'(32)) begin
                    n_state = S_FS1;
                end else begin
                    n_h = SHORT_INIT; n_state = S_FLEN;
                end
            end
            S_FS1: begin
                n_h  = rotl(r_lane[0], 1) + rotl(r_lane[1], 7);
                n_mv = rotl(r_lane[2], 12) + rotl(r_lane[3], 18);
                n_state = S_FS2;
            end
            S_FS2: begin
                n_h = r_h + r_mv; n_li = 2'd0; n_state = S_M0;
            end
            S_M0: begin
                n_ma = r_lane[r_li]; n_mb = PR2; n_ret = S_M1; n_state = S_MW1;
            end
            S_M1: begin
                n_ma = rotl(w_p, 31); n_mb = PR1; n_ret = S_M2; n_state = S_MW1;
            end
            S_M2: begin
                n_ma = r_h ^ w_p; n_mb = PR1; n_ret = S_M3; n_state = S_MW1;
            end
            S_M3: begin
                n_h = w_p + PR4;
                if (r_li == 2'd3) begin
                    n_state = S_FLEN;
                end else begin
                    n_li = r_li + 2'd1; n_state = S_M0;
                end
            end
            S_FLEN: begin
                n_h = r_h + 64'(r_len); n_i = '0; n_state = S_W0;
            end
            // tail words, half word, bytes
            S_W0: begin
                if (w_left >= 5'd8) begin
                    n_ma = w_sword; n_mb = PR2; n_ret = S_W1; n_state = S_MW1;
                end else if (w_left >= 5'd4) begin
                    n_ma = {32'd0, w_sword[31:0]}; n_mb = PR1;
                    n_ret = S_H1; n_state = S_MW1;
                end else begin
                    n_state = S_B0;
                end
            end
            S_W1: begin
                n_ma = rotl(w_p, 31); n_mb = PR1; n_ret = S_W2; n_state = S_MW1;
            end
            S_W2: begin
                n_ma = rotl(r_h ^ w_p, 27); n_mb = PR1; n_ret = S_W3; n_state = S_MW1;
            end
            S_W3: begin
                n_h = w_p + PR4; n_i = r_i + 5'd8; n_state = S_W0;
            end
            S_H1: begin
                n_ma = rotl(r_h ^ w_p, 23); n_mb = PR2; n_ret = S_H2; n_state = S_MW1;
            end
            S_H2: begin
                n_h = w_p + PR3; n_i = r_i + 5'd4; n_state = S_B0;
            end
            S_B0: begin
                if (r_i < r_len[4:0]) begin
                    n_ma = {56'd0, w_sword[{r_i[2:0], 3'b000} +: 8]}; n_mb = PR5;
                    n_ret = S_B1; n_state = S_MW1;
                end else begin
                    n_state = S_A0;
                end
            end
            S_B1: begin
                n_ma = rotl(r_h ^ w_p, 11); n_mb = PR1; n_ret = S_B2; n_state = S_MW1;
            end
            S_B2: begin
                n_h = w_p; n_i = r_i + 5'd1; n_state = S_B0;
            end
            // avalanche
            S_A0: begin
                n_ma = r_h ^ (r_h >> 33); n_mb = PR2; n_ret = S_A1; n_state = S_MW1;
            end
            S_A1: begin
                n_ma = w_p ^ (w_p >> 29); n_mb = PR3; n_ret = S_A2; n_state = S_MW1;
            end
            S_A2: begin
                n_h   = w_p ^ (w_p >> 32);
                n_mv  = w_p ^ (w_p >> 32);
                n_byh = 1'b1;
                n_rm  = '0;
                n_mc  = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_rm = w_rm;
                n_mv = r_mv << 8;
                n_mc = r_mc + 3'd1;
                if (r_mc == 3'd7) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_OUT;
            S_OUT: begin
                if (!r_ov || i_m_ready) begin
                    w_cnt_wr = 1'b1;
                    n_total  = r_total + 64'd1;
                    n_ov     = 1'b1;
                    n_opi    = r_rm[3:0];
                    n_obh    = r_byh;
                    n_oh     = r_h;
                    n_ocnt   = w_newcnt;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_nout  <= 5'd1;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_pv    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_nout  <= n_nout;
            r_total <= n_total;
            r_ov    <= n_ov;
            if (w_cnt_wr) begin
                r_pv[w_cidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane   <= n_lane;
        r_stripe <= n_stripe;
        r_h      <= n_h;
        r_mv     <= n_mv;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_li     <= n_li;
        r_i      <= n_i;
        r_len    <= n_len;
        r_done   <= n_done;
        r_rm     <= n_rm;
        r_mc     <= n_mc;
        r_byh    <= n_byh;
        r_opi    <= n_opi;
        r_obh    <= n_obh;
        r_oh     <= n_oh;
        r_ocnt   <= n_ocnt;
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_wr) begin
            r_cnt_mem[w_cidx] <= w_newcnt;
        end
        r_rd_cnt <= r_cnt_mem[w_cidx];
        r_rd_v   <= r_pv[w_cidx];
    end

    assign o_m_valid    = r_ov;
    assign o_port_index = r_opi;
    assign o_by_hash    = r_obh;
    assign o_hash       = r_oh;
    assign o_count      = r_ocnt;

endmodule

FILE: hdl/hfd_checker.sv
// hfd_checker: port-level assertions for hash_flow_distributor, bound to the top level
// depends on hash_flow_distributor port names and its MAX_PORTS parameter
`timescale 1ns / 1ps

module hfd_checker #(
    parameter int MAX_PORTS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_wen,
    input logic [4:0]   i_cfg_wdata,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [71:0]  s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    logic [4:0] r_n;
    logic [4:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 5'd1;
        end else if (i_cfg_wen) begin
            r_n <= i_cfg_wdata;
        end
    end

    assign w_n = (r_n == 5'd0) ? 5'd1 :
                 ((32'(r_n) > MAX_PORTS) ? 5'(MAX_PORTS) : r_n);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_rr_no_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[67:4] == 64'd0)
        else $error("round-robin result with nonzero hash");

    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[3:0]} < w_n)
        else $error("port index beyond ports in use");

endmodule

bind hash_flow_distributor hfd_checker #(.MAX_PORTS(MAX_PORTS)) u_hfd_checker (.*);

FILE: tb/tb_hash_flow_distributor.sv
`timescale 1ns / 1ps

// tb_hash_flow_distributor: self-checking bench for the hash flow distributor
// needs hfd_pkg and hash_flow_distributor; predicts each port choice with its own xxh64 routine

typedef struct packed {
    logic [3:0]  port;
    logic        by_hash;
    logic [63:0] hash;
    logic [63:0] count;
} t_choice;

// expected record results in arrival order, with field-by-field compare
class port_choice_board;
    t_choice pending[$];
    int      errors;

    function void note_record(t_choice c);
        pending.insert(pending.size(), c);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] exp_v);
        $display("error: %s got %h want %h at %0t", what, got, exp_v, $time);
        errors++;
    endtask

    task check_result(logic [3:0] port, logic by_hash, logic [63:0] hash,
                      logic [63:0] count);
        t_choice e;
        if (pending.size() == 0) begin
            report("unexpected result beat, port", {60'd0, port}, 64'd0);
            return;
        end
        e = pending.pop_front();
        if (port != e.port) report("port_index", {60'd0, port}, {60'd0, e.port});
        if (by_hash != e.by_hash) report("by_hash", {63'd0, by_hash}, {63'd0, e.by_hash});
        if (hash != e.hash) report("hash_value", hash, e.hash);
        if (count != e.count) report("port_count", count, e.count);
    endtask
endclass

module tb_hash_flow_distributor;
    import hfd_pkg::*;

    localparam int NPORT = 16;
    localparam int KEYMAX = 256;
    localparam int WATCHDOG = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [4:0]   i_cfg_wdata = 5'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tuser;

    hash_flow_distributor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    port_choice_board board = new();

    // predictor state
    logic [4:0]  ports_cfg;
    logic [63:0] lanes [4];
    logic [7:0]  key_buf [KEYMAX];
    int          key_len;
    logic [63:0] records_seen;
    logic [63:0] port_tally [NPORT];

    // stimulus control
    bit          quiet_in;       // no idling on the sender
    bit          quiet_out;      // no stalls on the receiver
    bit          hold_out;       // long receiver hold-off
    int          hold_cycles;
    int          idle_count;
    int          words_sent;
    int          results_seen;
    int          hashed_seen;

    function automatic logic [63:0] rotl(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] mix_round(logic [63:0] acc, logic [63:0] v);
        acc = acc + v * PR2;
        return rotl(acc, 31) * PR1;
    endfunction

    function automatic logic [63:0] stripe_word(int base);
        logic [63:0] w;
        w = '0;
        for (int b = 0; b < 8; b++) w[b*8 +: 8] = key_buf[base + b];
        return w;
    endfunction

    // xxh64 over the bytes gathered for the current record
    function automatic logic [63:0] xxh64_key();
        logic [63:0] h;
        logic [63:0] v;
        int          i;
        i = 0;
        if (key_len >= 32) begin
            h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
            for (int l = 0; l < 4; l++) begin
                h = h ^ mix_round(64'd0, lanes[l]);
                h = h * PR1 + PR4;
            end
        end else begin
            h = HASH_SEED + PR5;
        end
        h = h + 64'(key_len);
        i = key_len - (key_len % 32);
        while (key_len - i >= 8) begin
            h = h ^ mix_round(64'd0, stripe_word(i));
            h = rotl(h, 27) * PR1 + PR4;
            i += 8;
        end
        if (key_len - i >= 4) begin
            v = {32'd0, key_buf[i+3], key_buf[i+2], key_buf[i+1], key_buf[i]};
            h = h ^ (v * PR1);
            h = rotl(h, 23) * PR2 + PR3;
            i += 4;
        end
        while (i < key_len) begin
            h = h ^ (64'(key_buf[i]) * PR5);
            h = rotl(h, 11) * PR1;
            i++;
        end
        h = h ^ (h >> 33);
        h = h * PR2;
        h = h ^ (h >> 29);
        h = h * PR3;
        h = h ^ (h >> 32);
        return h;
    endfunction

    // fold one accepted beat into the predictor, queue a result when a record ends
    task automatic predict_beat(logic keyed, logic [63:0] word, logic [3:0] nbytes, logic last);
        int          n;
        int          nb;
        logic [63:0] h;
        logic [63:0] port;
        bit          hashed;
        t_choice     c;
        n = (ports_cfg == 0) ? 1 : ((ports_cfg > NPORT) ? NPORT : ports_cfg);
        h = '0;
        hashed = 0;
        if (keyed) begin
            if (key_len == 0)
                lanes = '{HASH_SEED + PR1 + PR2, HASH_SEED + PR2, HASH_SEED, HASH_SEED - PR1};
            nb = (!last || nbytes > 8) ? 8 : nbytes;
            for (int k = 0; k < nb; k++) begin
                if (key_len < KEYMAX) begin
                    key_buf[key_len] = word[k*8 +: 8];
                    key_len++;
                    if (key_len % 32 == 0)
                        for (int l = 0; l < 4; l++)
                            lanes[l] = mix_round(lanes[l], stripe_word(key_len - 32 + 8*l));
                end
            end
            if (!last) return;
            if (key_len > 0) begin
                h = xxh64_key();
                hashed = 1;
            end
        end
        key_len = 0;
        port = hashed ? (h % 64'(n)) : (records_seen % 64'(n));
        records_seen++;
        port_tally[port[3:0]]++;
        c.port = port[3:0];
        c.by_hash = hashed;
        c.hash = h;
        c.count = port_tally[port[3:0]];
        board.note_record(c);
    endtask

    // offer one beat and wait for acceptance, with random gaps ahead of it unless quiet_in is set
    task automatic send_beat(logic keyed, logic [63:0] word, logic [3:0] nbytes, logic last);
        if (!quiet_in) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, nbytes, word};
        s_axis_tlast  <= last;
        s_axis_tuser  <= keyed;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_beat(keyed, word, nbytes, last);
        words_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // keyed record of a given length in bytes, full words then a tail word of up to eight bytes
    task automatic send_key(int nbytes);
        int left;
        left = nbytes;
        while (left > 8) begin
            send_beat(1'b1, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
            left -= 8;
        end
        send_beat(1'b1, {$urandom, $urandom}, 4'(left), 1'b1);
    endtask

    task automatic drain();
        stop_sending();
        while (board.pending.size() != 0) @(posedge i_clk);
        // let the back end settle before any port count change
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_ports(logic [4:0] v);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        ports_cfg = v;
        @(posedge i_clk);
    endtask

    task automatic random_record();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            send_beat(1'b0, {$urandom, $urandom}, 4'($urandom_range(15)), 1'($urandom));
        else if (pick < 85)
            send_key(($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 20));
        else if (pick < 90)
            send_key($urandom_range(250, 270));
        else if (pick < 95)
            // broken record: a keyed prefix cut off by an unkeyed beat
            begin
                send_beat(1'b1, {$urandom, $urandom}, 4'd8, 1'b0);
                send_beat(1'b0, {$urandom, $urandom}, 4'($urandom_range(15)), 1'($urandom));
            end
        else
            send_beat(1'b1, {$urandom, $urandom}, 4'($urandom_range(9, 15)), 1'b1);
    endtask

    // result side: random stalls, none when quiet_out is set, or a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_out) begin
            m_axis_tready <= 1'b0;
            hold_cycles++;
        end else begin
            m_axis_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    // result beats are taken and checked at the edge they are accepted on
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[67:4],
                               m_axis_tdata[131:68]);
            results_seen++;
            if (m_axis_tuser) hashed_seen++;
        end
    end

    // watchdog on cycles without any accepted beat, paused during a hold-off
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_out)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        ports_cfg = 5'd1;
        key_len = 0;
        records_seen = '0;
        for (int p = 0; p < NPORT; p++) port_tally[p] = '0;
        quiet_in = 0;
        quiet_out = 0;
        hold_out = 0;
        hold_cycles = 0;
        idle_count = 0;
        words_sent = 0;
        results_seen = 0;
        hashed_seen = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset count of one port, field extremes and special cases
        send_beat(1'b0, '0, 4'd0, 1'b0);
        send_beat(1'b1, '1, 4'd8, 1'b1);
        send_beat(1'b1, '0, 4'd1, 1'b1);
        drain();
        write_ports(5'd16);
        send_beat(1'b0, '1, 4'd15, 1'b1);
        send_beat(1'b1, 64'h0123_4567_89ab_cdef, 4'd15, 1'b1);  // byte count above eight
        send_beat(1'b1, {$urandom, $urandom}, 4'd3, 1'b0);      // short inner word
        send_beat(1'b1, {$urandom, $urandom}, 4'd4, 1'b1);
        send_beat(1'b1, '1, 4'd0, 1'b1);                        // empty key
        send_beat(1'b1, '1, 4'd8, 1'b0);                        // abandoned by unkeyed beat
        send_beat(1'b0, '0, 4'd8, 1'b1);
        send_key(32);
        send_key(37);
        send_key(300);                                          // key too long
        drain();
        write_ports(5'd0);                                      // acts as one port
        send_key(5);
        send_beat(1'b0, '0, 4'd0, 1'b1);
        drain();
        write_ports(5'd31);                                     // clamps to sixteen
        send_key(12);
        send_beat(1'b0, '0, 4'd0, 1'b1);
        drain();

        // random phases across several port counts
        for (int ph = 0; ph < 6; ph++) begin
            write_ports((ph == 0) ? 5'd1 : ((ph == 1) ? 5'd16 : 5'($urandom_range(31))));
            quiet_in  = (ph == 2);
            quiet_out = (ph == 2);
            while (words_sent < 40 + (ph + 1) * 135) begin
                random_record();
                if (ph == 3 && hold_cycles == 0 && words_sent > 400) begin
                    // receiver holds off while the sender keeps going
                    hold_out = 1;
                    fork
                        begin
                            repeat (400) @(posedge i_clk);
                            hold_out = 0;
                        end
                    join_none
                end
            end
            drain();
        end

        $display("covered %0d input beats, %0d records (%0d hashed)",
                 words_sent, results_seen, hashed_seen);
        $display("port settings 0, 1, 16, 31 and random ones, with stalls and a long hold-off");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: hash_flow_distributor.f
hdl/hfd_pkg.sv
hdl/hfd_mul64.sv
hdl/hfd_front.sv
hdl/hfd_queue.sv
hdl/hfd_back.sv
hdl/hash_flow_distributor.sv
hdl/hfd_checker.sv
tb/tb_hash_flow_distributor.sv
